// ----- rtl/mqsb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and constants of the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_QUEUES     = 4;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int QID_W  = 2;
  localparam int WORD_W = 32;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // write strobes into the queue head/tail table
  typedef struct packed {
    logic head_we;
    logic tail_we;
  } qt_wr_t;

endpackage

// ----- rtl/multi_queue_shared_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit
// Several FIFO queues in one linked entry store with a free list.
// ----------------------------------------------------------------------------
// Flow: an accepted request moves the block to its finish state, which
//   registers the result; dropped items take the same path.
// Requests: none is taken until the finish state completes; the registered
//   read of the link memory at acceptance feeds the pointer updates of the
//   finish state. A stalled result holds the block there until it transfers.
// Reset: synchronous; queue pointers go null, the free list restarts at entry
//   0. Untouched entries are tracked by a fill count, so no clearing pass runs.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_unit
  import mqsb_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int QUEUES     = DEF_QUEUES,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [QID_W-1:0]         in_queue_id,
  input  logic signed [WORD_W-1:0] in_data_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_data_out
);

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  typedef enum logic {S_IDLE, S_FIN} state_t;

  state_t        state_r, state_nxt;
  logic          op_r, op_nxt;
  logic          ok_r, ok_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;

  logic          accept, go, q_in_range, head_null;
  logic [QW-1:0] rd_qid;
  logic [PW-1:0] head_rd, tail_rd;
  qt_wr_t        qt_wr;
  logic [PW-1:0] qt_head_d, qt_tail_d;

  logic                  lk_we, lk_re;
  logic [AW-1:0]         lk_waddr, lk_raddr;
  logic [PW-1:0]         lk_wdata, lk_rdata;
  logic                  dt_we, dt_re;
  logic [AW-1:0]         dt_waddr, dt_raddr;
  logic [DATA_WIDTH-1:0] dt_wdata, dt_rdata;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign go         = !out_valid_r || !out_stall;
  assign q_in_range = (32'(in_queue_id) < QUEUES);
  assign rd_qid     = (state_r == S_IDLE) ? QW'(in_queue_id) : q_r;
  assign head_null  = (head_rd == NIL);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ok_nxt         = ok_r;
    q_nxt          = q_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    qt_wr          = '0;
    qt_head_d      = free_head_r;
    qt_tail_d      = free_head_r;
    lk_we          = 1'b0;
    lk_waddr       = free_head_r[AW-1:0];
    lk_wdata       = NIL;
    lk_re          = 1'b0;
    lk_raddr       = free_head_r[AW-1:0];
    dt_we          = 1'b0;
    dt_waddr       = free_head_r[AW-1:0];
    dt_wdata       = DATA_WIDTH'($unsigned(in_data_in));
    dt_re          = 1'b0;
    dt_raddr       = head_rd[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_func;
          q_nxt     = QW'(in_queue_id);
          state_nxt = S_FIN;
          if (in_func == FUNC_ENQ) begin
            ok_nxt = q_in_range && (free_head_r != NIL);
            // fetch the next free entry and terminate the new one
            lk_re  = ok_nxt;
            lk_we  = ok_nxt;
            dt_we  = ok_nxt;
          end else begin
            ok_nxt   = q_in_range && !head_null;
            lk_re    = ok_nxt;
            lk_raddr = head_rd[AW-1:0];
            dt_re    = ok_nxt;
          end
        end
      end
      S_FIN: begin
        if (go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == FUNC_ENQ) begin
            out_data_nxt = '0;
            if (ok_r) begin
              out_status_nxt = ST_OK;
              qt_wr.head_we  = head_null;
              qt_wr.tail_we  = 1'b1;
              lk_we          = !head_null;
              lk_waddr       = tail_rd[AW-1:0];
              lk_wdata       = free_head_r;
              // an entry at the fill mark was never linked: it chains to the next
              if (free_head_r == fill_r) begin
                free_head_nxt = free_head_r + PW'(1);
                fill_nxt      = fill_r + PW'(1);
              end else begin
                free_head_nxt = lk_rdata;
              end
            end else begin
              out_status_nxt = ST_FULL;
            end
          end else begin
            if (ok_r) begin
              out_status_nxt = ST_OK;
              out_data_nxt   = WORD_W'(dt_rdata);
              qt_wr.head_we  = 1'b1;
              qt_head_d      = lk_rdata;
              lk_we          = 1'b1;
              lk_waddr       = head_rd[AW-1:0];
              lk_wdata       = free_head_r;
              free_head_nxt  = head_rd;
            end else begin
              out_status_nxt = ST_EMPTY;
              out_data_nxt   = WORD_W'({DATA_WIDTH{1'b1}});
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    ok_r         <= ok_nxt;
    q_r          <= q_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = $signed(out_data_r);

  mqsb_qtable #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) u_qtable (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_qid (rd_qid),
    .head_q (head_rd),
    .tail_q (tail_rd),
    .wr_qid (q_r),
    .wr     (qt_wr),
    .head_d (qt_head_d),
    .tail_d (qt_tail_d)
  );

  mqsb_ram #(
    .WIDTH (PW),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  mqsb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (dt_we),
    .waddr (dt_waddr),
    .wdata (dt_wdata),
    .re    (dt_re),
    .raddr (dt_raddr),
    .rdata (dt_rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NIL)
    else $error("fill count beyond entry count");

  a_free_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= fill_r)
    else $error("free list head above fill mark");

  a_enq_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && op_r == FUNC_ENQ && ok_r) |-> (free_head_r != NIL))
    else $error("enqueue without a free entry");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

endmodule

// ----- rtl/mqsb_ram.sv -----
// ----------------------------------------------------------------------------
// mqsb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read and a write to the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module mqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mqsb_qtable.sv -----
// ----------------------------------------------------------------------------
// mqsb_qtable
// Head and tail pointer of every queue, one read index and one write index.
// ----------------------------------------------------------------------------
module mqsb_qtable
  import mqsb_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int QUEUES  = DEF_QUEUES,
  localparam int PW     = $clog2(ENTRIES + 1),
  localparam int QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [QW-1:0] rd_qid,
  output logic [PW-1:0] head_q,
  output logic [PW-1:0] tail_q,
  input  logic [QW-1:0] wr_qid,
  input  qt_wr_t        wr,
  input  logic [PW-1:0] head_d,
  input  logic [PW-1:0] tail_d
);

  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  logic [PW-1:0] head_r [QUEUES];
  logic [PW-1:0] tail_r [QUEUES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
    end else begin
      if (wr.head_we) begin
        head_r[wr_qid] <= head_d;
      end
      if (wr.tail_we) begin
        tail_r[wr_qid] <= tail_d;
      end
    end
  end

  assign head_q = head_r[rd_qid];
  assign tail_q = tail_r[rd_qid];

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-queue shared buffer. A queue of
// enqueue/dequeue requests feeds a clocked driver; a clocked monitor predicts
// each result from its own linked-list model of the store and compares every
// result transfer in order. Random segments lean toward enqueue or dequeue so
// the store fills up, overflows and drains repeatedly. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import mqsb_pkg::*;

  localparam int ENTRIES      = DEF_ENTRIES;
  localparam int QUEUES       = DEF_QUEUES;
  localparam int PTR_W        = $clog2(ENTRIES + 1);
  localparam logic [PTR_W-1:0] NULL_LINK = PTR_W'(ENTRIES);
  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_PCT     = 31;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;
  localparam int QUIET_FROM   = 500;
  localparam int QUIET_TO     = 700;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic              func;
    logic [QID_W-1:0]  qid;
    logic [WORD_W-1:0] word;
  } queue_op_t;

  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] word;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_ENQ;
  logic [QID_W-1:0] in_queue_id = '0;
  logic signed [WORD_W-1:0] in_data_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [WORD_W-1:0] out_data_out;

  // local copy of the queue store
  logic [PTR_W-1:0]  head_ptr [QUEUES];
  logic [PTR_W-1:0]  tail_ptr [QUEUES];
  logic [PTR_W-1:0]  link_mem [ENTRIES];
  logic [WORD_W-1:0] word_mem [ENTRIES];
  logic [PTR_W-1:0]  free_ptr;

  queue_op_t     pending_ops[$];
  queue_result_t awaited_results[$];
  queue_op_t     next_op;
  queue_result_t oldest;

  int  items_in = 0;
  int  errors = 0;
  int  stuck_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  n_ok = 0;
  int  n_full = 0;
  int  n_empty = 0;
  logic quiet_window;

  assign quiet_window = items_in >= QUIET_FROM && items_in < QUIET_TO;

  multi_queue_shared_buffer_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_out (out_data_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_store_model();
    for (int q = 0; q < QUEUES; q++) begin
      head_ptr[q] = NULL_LINK;
      tail_ptr[q] = NULL_LINK;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      link_mem[i] = PTR_W'(i + 1);
      word_mem[i] = '0;
    end
    free_ptr = '0;
  endfunction

  function automatic queue_result_t predict_queue_op(logic func, logic [QID_W-1:0] qid,
                                                     logic [WORD_W-1:0] word);
    queue_result_t r;
    logic [PTR_W-1:0] slot;
    r.status = ST_OK;
    r.word = '0;
    if (func == FUNC_ENQ) begin
      slot = free_ptr;
      if (qid >= QUEUES || slot >= ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        free_ptr = link_mem[slot];
        if (head_ptr[qid] >= ENTRIES) begin
          head_ptr[qid] = slot;
        end else if (tail_ptr[qid] < ENTRIES) begin
          link_mem[tail_ptr[qid]] = slot;
        end
        link_mem[slot] = NULL_LINK;
        tail_ptr[qid] = slot;
        word_mem[slot] = word;
      end
    end else begin
      slot = (qid < QUEUES) ? head_ptr[qid] : NULL_LINK;
      if (slot >= ENTRIES) begin
        r.status = ST_EMPTY;
        r.word = '1;
      end else begin
        head_ptr[qid] = link_mem[slot];
        link_mem[slot] = free_ptr;
        free_ptr = slot;
        r.word = word_mem[slot];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (errors < 20)
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic add_op(logic func, logic [QID_W-1:0] qid, logic [WORD_W-1:0] word);
    queue_op_t op;
    op.func = func;
    op.qid = qid;
    op.word = word;
    pending_ops.push_back(op);
  endtask

  // driver: advance to the next request once the current one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_ops.size() != 0 && (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
        next_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_func <= next_op.func;
        in_queue_id <= next_op.qid;
        in_data_in <= next_op.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet_window && $urandom_range(99) < IDLE_PCT;
    end
  end

  // monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_queue_op(in_func, in_queue_id, in_data_in));
        items_in <= items_in + 1;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status/data", WORD_W'(out_status), out_data_out);
        end else begin
          oldest = awaited_results.pop_front();
          if (out_status !== oldest.status)
            report_mismatch("status", WORD_W'(out_status), WORD_W'(oldest.status));
          if (out_data_out !== oldest.word)
            report_mismatch("data_out", out_data_out, oldest.word);
          case (oldest.status)
            ST_OK:    n_ok++;
            ST_FULL:  n_full++;
            default:  n_empty++;
          endcase
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int enq_pct [5];
    int made;
    int seg;
    int seg_len;
    int pct;
    int focus_q;
    bit focused;
    logic [QID_W-1:0] qid;

    clear_store_model();

    // directed: empty queues, word extremes, emptying a queue and refilling it
    for (int q = 0; q < QUEUES; q++)
      add_op(FUNC_DEQ, QID_W'(q), $urandom());
    add_op(FUNC_ENQ, QID_W'(0), 32'h7fff_ffff);
    add_op(FUNC_ENQ, QID_W'(0), 32'h8000_0000);
    add_op(FUNC_ENQ, QID_W'(1), 32'hffff_ffff);
    add_op(FUNC_ENQ, QID_W'(2), 32'h0000_0000);
    add_op(FUNC_ENQ, QID_W'(3), 32'h5555_5555);
    add_op(FUNC_DEQ, QID_W'(0), 32'hffff_ffff);
    add_op(FUNC_DEQ, QID_W'(0), 32'h0000_0000);
    add_op(FUNC_DEQ, QID_W'(0), 32'h1234_5678);
    add_op(FUNC_ENQ, QID_W'(0), 32'haaaa_aaaa);
    add_op(FUNC_ENQ, QID_W'(0), 32'h0000_0001);
    add_op(FUNC_DEQ, QID_W'(1), 32'h0);
    add_op(FUNC_DEQ, QID_W'(2), 32'h0);
    add_op(FUNC_DEQ, QID_W'(3), 32'h0);
    add_op(FUNC_DEQ, QID_W'(0), 32'h0);
    add_op(FUNC_DEQ, QID_W'(0), 32'h0);
    add_op(FUNC_DEQ, QID_W'(1), 32'h0);

    // random: segments biased to fill past capacity or drain to empty
    enq_pct = '{95, 50, 5, 70, 30};
    made = 0;
    seg = 0;
    while (made < RANDOM_ITEMS) begin
      seg_len = $urandom_range(140, 80);
      pct = enq_pct[seg % 5];
      focus_q = $urandom_range(QUEUES - 1);
      focused = 1'($urandom_range(1));
      for (int i = 0; i < seg_len; i++) begin
        qid = (focused && $urandom_range(3) != 0) ? QID_W'(focus_q)
                                                   : QID_W'($urandom_range(QUEUES - 1));
        add_op(($urandom_range(99) < pct) ? FUNC_ENQ : FUNC_DEQ, qid, $urandom());
      end
      made += seg_len;
      seg++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests: %0d ok, %0d dropped on a full store,", items_in,
             n_ok, n_full);
    $display("%0d dequeues from empty queues, %0d mismatches", n_empty, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
